// File: sv/cfid_pkg.sv
// Package for the contiguous frame interval deque.
// Holds command codes, operation and status types, and parameter defaults.
// No dependencies.
package cfid_pkg;

    localparam int DEF_NUM_FRAMES  = 64;
    localparam int DEF_TIME_BITS   = 48;
    localparam int DEF_HANDLE_BITS = 32;

    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [2:0] CMD_POP_BACK   = 3'd2;
    localparam logic [2:0] CMD_FIND       = 3'd3;
    localparam logic [2:0] CMD_TRIM_FRONT = 3'd4;
    localparam logic [2:0] CMD_TRIM_BACK  = 3'd5;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_FIND,
        OP_TRIM_FRONT,
        OP_TRIM_BACK,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NOT_ADJ = 3'd2,
        ST_FULL    = 3'd3,
        ST_BAD_IVL = 3'd4,
        ST_COUNT   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_TRIM1,
        S_TRIM2,
        S_SRCH,
        S_CMP,
        S_FOUND
    } state_t;

    // Map a raw command code onto an operation; unused codes do nothing.
    function automatic op_t classify(input logic [2:0] cmd);
        op_t op;
        unique case (cmd)
            CMD_APPEND:     op = OP_APPEND;
            CMD_POP_FRONT:  op = OP_POP_FRONT;
            CMD_POP_BACK:   op = OP_POP_BACK;
            CMD_FIND:       op = OP_FIND;
            CMD_TRIM_FRONT: op = OP_TRIM_FRONT;
            CMD_TRIM_BACK:  op = OP_TRIM_BACK;
            default:        op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

// File: sv/cfid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/cfid_front.sv
// Front end: takes command transfers, classifies them and holds them in a
// two-entry queue for the back end. Depends on cfid_pkg.
module cfid_front #(
    parameter int TIME_BITS   = 48,
    parameter int HANDLE_BITS = 32,
    parameter int CW          = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             command,
    input  logic [TIME_BITS-1:0]   start_time,
    input  logic [TIME_BITS-1:0]   end_time,
    input  logic [HANDLE_BITS-1:0] picture_handle,
    input  logic [TIME_BITS-1:0]   query_time,
    input  logic [CW-1:0]          trim_count,
    output logic                   q_valid,
    input  logic                   q_pop,
    output cfid_pkg::op_t          q_op,
    output logic [TIME_BITS-1:0]   q_ts,
    output logic [TIME_BITS-1:0]   q_te,
    output logic [HANDLE_BITS-1:0] q_ph,
    output logic [TIME_BITS-1:0]   q_q,
    output logic [CW-1:0]          q_n
);
    import cfid_pkg::*;

    op_t                   op_reg [2];
    logic [TIME_BITS-1:0]  ts_reg [2];
    logic [TIME_BITS-1:0]  te_reg [2];
    logic [HANDLE_BITS-1:0] ph_reg [2];
    logic [TIME_BITS-1:0]  qt_reg [2];
    logic [CW-1:0]         n_reg  [2];
    logic                  wp_reg, wp_next;
    logic                  rp_reg, rp_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = op_reg[rp_reg];
    assign q_ts    = ts_reg[rp_reg];
    assign q_te    = te_reg[rp_reg];
    assign q_ph    = ph_reg[rp_reg];
    assign q_q     = qt_reg[rp_reg];
    assign q_n     = n_reg[rp_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = (q_pop && q_valid) ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wp_reg] <= classify(command);
            ts_reg[wp_reg] <= start_time;
            te_reg[wp_reg] <= end_time;
            ph_reg[wp_reg] <= picture_handle;
            qt_reg[wp_reg] <= query_time;
            n_reg[wp_reg]  <= trim_count;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue popped while empty");
`endif

endmodule

// File: sv/cfid_back.sv
// Back end: frame ring store, span bounds and the command sequencer,
// including the binary search for find. Depends on cfid_pkg and cfid_ram.
module cfid_back #(
    parameter int NUM_FRAMES  = 64,
    parameter int TIME_BITS   = 48,
    parameter int HANDLE_BITS = 32,
    parameter int CW          = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  cfid_pkg::op_t          q_op,
    input  logic [TIME_BITS-1:0]   q_ts,
    input  logic [TIME_BITS-1:0]   q_te,
    input  logic [HANDLE_BITS-1:0] q_ph,
    input  logic [TIME_BITS-1:0]   q_q,
    input  logic [CW-1:0]          q_n,
    output logic                   done,
    output logic [2:0]             status,
    output logic [HANDLE_BITS-1:0] picture_out,
    output logic [TIME_BITS-1:0]   frame_begin,
    output logic [TIME_BITS-1:0]   frame_finish,
    output logic [TIME_BITS-1:0]   span_start,
    output logic [TIME_BITS-1:0]   span_stop,
    output logic                   span_valid,
    output logic [CW-1:0]          frames_held
);
    import cfid_pkg::*;

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int W  = 2 * TIME_BITS + HANDLE_BITS;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [TIME_BITS-1:0]  qt_reg, qt_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [TIME_BITS-1:0]  bstart_reg, bstart_next;
    logic [TIME_BITS-1:0]  bstop_reg, bstop_next;
    logic                  bok_reg, bok_next;
    logic [IW-1:0]         lo_reg, lo_next;
    logic [IW-1:0]         hi_reg, hi_next;
    logic [IW-1:0]         mid_reg, mid_next;
    logic                  done_reg, done_next;
    logic [2:0]            status_reg, status_next;
    logic [HANDLE_BITS-1:0] pic_reg, pic_next;
    logic [TIME_BITS-1:0]  fb_reg, fb_next;
    logic [TIME_BITS-1:0]  ff_reg, ff_next;
    logic [TIME_BITS-1:0]  sps_reg, sps_next;
    logic [TIME_BITS-1:0]  spe_reg, spe_next;
    logic                  spv_reg, spv_next;
    logic [CW-1:0]         held_reg, held_next;

    logic                  we;
    logic [IW-1:0]         waddr, raddr, ptmp, nh;
    logic [W-1:0]          wdata, rdata;
    logic [TIME_BITS-1:0]  rd_start, rd_end;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic                  emit;
    status_t               st;
    logic [HANDLE_BITS-1:0] pic;
    logic [TIME_BITS-1:0]  fb, ff;
    logic [IW:0]           msum;
    logic [CW-1:0]         nc;

    // Ring position of the k-th frame counted from head h.
    function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] k);
        logic [IW+1:0] s;
        s = {2'b00, h} + (IW+2)'(k);
        if (s >= (IW+2)'(NUM_FRAMES))
        begin
            s = s - (IW+2)'(NUM_FRAMES);
        end
        return s[IW-1:0];
    endfunction

    cfid_ram #(
        .WIDTH (W),
        .DEPTH (NUM_FRAMES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_start  = rdata[W-1 -: TIME_BITS];
    assign rd_end    = rdata[HANDLE_BITS +: TIME_BITS];
    assign rd_handle = rdata[HANDLE_BITS-1:0];

    // Sequencer: next state, store access and result formation.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        qt_next     = qt_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        bstart_next = bstart_reg;
        bstop_next  = bstop_reg;
        bok_next    = bok_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = {q_ts, q_te, q_ph};
        raddr       = '0;
        emit        = 1'b0;
        st          = ST_OK;
        pic         = '0;
        fb          = '0;
        ff          = '0;
        ptmp        = '0;
        nh          = '0;
        nc          = '0;
        msum        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    op_next = q_op;
                    qt_next = q_q;
                    unique case (q_op)
                        OP_APPEND:
                        begin
                            emit = 1'b1;
                            if (q_te <= q_ts)
                            begin
                                st = ST_BAD_IVL;
                            end
                            else if (count_reg == '0)
                            begin
                                we          = 1'b1;
                                waddr       = '0;
                                head_next   = '0;
                                count_next  = CW'(1);
                                bstart_next = q_ts;
                                bstop_next  = q_te;
                                bok_next    = 1'b1;
                            end
                            else if (q_ts == bstop_reg)
                            begin
                                if (count_reg >= CW'(NUM_FRAMES))
                                begin
                                    st = ST_FULL;
                                end
                                else
                                begin
                                    we         = 1'b1;
                                    waddr      = slot(head_reg, count_reg);
                                    count_next = count_reg + CW'(1);
                                    bstop_next = q_te;
                                end
                            end
                            else if (q_te == bstart_reg)
                            begin
                                if (count_reg >= CW'(NUM_FRAMES))
                                begin
                                    st = ST_FULL;
                                end
                                else
                                begin
                                    ptmp        = (head_reg == '0) ? IW'(NUM_FRAMES - 1)
                                                                   : head_reg - IW'(1);
                                    we          = 1'b1;
                                    waddr       = ptmp;
                                    head_next   = ptmp;
                                    count_next  = count_reg + CW'(1);
                                    bstart_next = q_ts;
                                end
                            end
                            else
                            begin
                                st = ST_NOT_ADJ;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                emit        = 1'b1;
                                st          = ST_EMPTY;
                                bstart_next = '0;
                                bstop_next  = '0;
                                bok_next    = 1'b0;
                            end
                            else
                            begin
                                raddr      = (q_op == OP_POP_FRONT) ? head_reg
                                             : slot(head_reg, count_reg - CW'(1));
                                state_next = S_POP;
                            end
                        end
                        OP_FIND:
                        begin
                            if (count_reg != '0 && bstart_reg <= q_q && q_q < bstop_reg)
                            begin
                                lo_next    = '0;
                                hi_next    = IW'(count_reg - CW'(1));
                                state_next = S_SRCH;
                            end
                            else
                            begin
                                emit = 1'b1;
                                st   = ST_EMPTY;
                            end
                        end
                        OP_TRIM_FRONT, OP_TRIM_BACK:
                        begin
                            if (q_n > count_reg)
                            begin
                                emit = 1'b1;
                                st   = ST_COUNT;
                            end
                            else
                            begin
                                nh         = (q_op == OP_TRIM_FRONT) ? slot(head_reg, q_n)
                                                                     : head_reg;
                                nc         = count_reg - q_n;
                                head_next  = nh;
                                count_next = nc;
                                if (nc == '0)
                                begin
                                    emit        = 1'b1;
                                    bstart_next = '0;
                                    bstop_next  = '0;
                                    bok_next    = 1'b0;
                                end
                                else
                                begin
                                    raddr      = nh;
                                    state_next = S_TRIM1;
                                end
                            end
                        end
                        OP_NOP:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                emit       = 1'b1;
                pic        = rd_handle;
                count_next = count_reg - CW'(1);
                if (op_reg == OP_POP_FRONT)
                begin
                    bstart_next = rd_end;
                    head_next   = slot(head_reg, CW'(1));
                end
                else
                begin
                    bstop_next = rd_start;
                end
                state_next = S_IDLE;
            end
            S_TRIM1:
            begin
                bstart_next = rd_start;
                raddr       = slot(head_reg, count_reg - CW'(1));
                state_next  = S_TRIM2;
            end
            S_TRIM2:
            begin
                emit       = 1'b1;
                bstop_next = rd_end;
                bok_next   = 1'b1;
                state_next = S_IDLE;
            end
            S_SRCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    raddr      = slot(head_reg, CW'(lo_reg));
                    state_next = S_FOUND;
                end
                else
                begin
                    msum       = {1'b0, lo_reg} + {1'b0, hi_reg} + (IW+1)'(1);
                    mid_next   = msum[IW:1];
                    raddr      = slot(head_reg, CW'(msum[IW:1]));
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_start <= qt_reg)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg - IW'(1);
                end
                state_next = S_SRCH;
            end
            S_FOUND:
            begin
                emit       = 1'b1;
                pic        = rd_handle;
                fb         = rd_start;
                ff         = rd_end;
                state_next = S_IDLE;
            end
        endcase

        // Result register loads with the state after the step.
        done_next   = emit;
        status_next = emit ? st : status_reg;
        pic_next    = emit ? pic : pic_reg;
        fb_next     = emit ? fb : fb_reg;
        ff_next     = emit ? ff : ff_reg;
        sps_next    = emit ? bstart_next : sps_reg;
        spe_next    = emit ? bstop_next : spe_reg;
        spv_next    = emit ? bok_next : spv_reg;
        held_next   = emit ? count_next : held_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            bstart_reg <= '0;
            bstop_reg  <= '0;
            bok_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            bstart_reg <= bstart_next;
            bstop_reg  <= bstop_next;
            bok_reg    <= bok_next;
            done_reg   <= done_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        qt_reg     <= qt_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        status_reg <= status_next;
        pic_reg    <= pic_next;
        fb_reg     <= fb_next;
        ff_reg     <= ff_next;
        sps_reg    <= sps_next;
        spe_reg    <= spe_next;
        spv_reg    <= spv_next;
        held_reg   <= held_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign picture_out  = pic_reg;
    assign frame_begin  = fb_reg;
    assign frame_finish = ff_reg;
    assign span_start   = sps_reg;
    assign span_stop    = spe_reg;
    assign span_valid   = spv_reg;
    assign frames_held  = held_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NUM_FRAMES)) else $error("frame count beyond capacity");
    a_held_span: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> bok_reg) else $error("frames held with invalid span");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE) else $error("queue taken while busy");
    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH |-> lo_reg <= hi_reg) else $error("search bounds crossed");
`endif

endmodule

// File: sv/contiguous_frame_interval_deque.sv
// Top level of the contiguous frame interval deque.
// Depends on cfid_pkg, cfid_front and cfid_back.
//
// Commands are taken when start is high and busy is low; a two-entry queue
// lets up to two commands wait while one executes, and busy rises when it is
// full. Each command gives exactly one result, shown for one cycle with done
// high; results cannot be held off. Append, unused codes and refused commands
// finish in the idle state; pops read the frame store once and trims that
// leave frames read it twice. Find runs a binary search over the held frames
// through the single read port of the frame store, reading one frame a step.
// No clearing pass follows reset.
module contiguous_frame_interval_deque #(
    parameter int NUM_FRAMES  = cfid_pkg::DEF_NUM_FRAMES,
    parameter int TIME_BITS   = cfid_pkg::DEF_TIME_BITS,
    parameter int HANDLE_BITS = cfid_pkg::DEF_HANDLE_BITS,
    parameter int CW          = $clog2(NUM_FRAMES + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             command,
    input  logic [TIME_BITS-1:0]   start_time,
    input  logic [TIME_BITS-1:0]   end_time,
    input  logic [HANDLE_BITS-1:0] picture_handle,
    input  logic [TIME_BITS-1:0]   query_time,
    input  logic [CW-1:0]          trim_count,
    output logic                   done,
    output logic [2:0]             status,
    output logic [HANDLE_BITS-1:0] picture_out,
    output logic [TIME_BITS-1:0]   frame_begin,
    output logic [TIME_BITS-1:0]   frame_finish,
    output logic [TIME_BITS-1:0]   span_start,
    output logic [TIME_BITS-1:0]   span_stop,
    output logic                   span_valid,
    output logic [CW-1:0]          frames_held
);
    import cfid_pkg::*;

    logic                   q_valid, q_pop;
    op_t                    q_op;
    logic [TIME_BITS-1:0]   q_ts, q_te, q_q;
    logic [HANDLE_BITS-1:0] q_ph;
    logic [CW-1:0]          q_n;

    // Command intake and queue.
    cfid_front #(
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .CW          (CW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .start_time     (start_time),
        .end_time       (end_time),
        .picture_handle (picture_handle),
        .query_time     (query_time),
        .trim_count     (trim_count),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_op           (q_op),
        .q_ts           (q_ts),
        .q_te           (q_te),
        .q_ph           (q_ph),
        .q_q            (q_q),
        .q_n            (q_n)
    );

    // Frame store and command execution.
    cfid_back #(
        .NUM_FRAMES  (NUM_FRAMES),
        .TIME_BITS   (TIME_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .CW          (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (q_op),
        .q_ts         (q_ts),
        .q_te         (q_te),
        .q_ph         (q_ph),
        .q_q          (q_q),
        .q_n          (q_n),
        .done         (done),
        .status       (status),
        .picture_out  (picture_out),
        .frame_begin  (frame_begin),
        .frame_finish (frame_finish),
        .span_start   (span_start),
        .span_stop    (span_stop),
        .span_valid   (span_valid),
        .frames_held  (frames_held)
    );

endmodule

// File: verif/tb_contiguous_frame_interval_deque.sv
// Self-checking testbench for the contiguous frame interval deque.
// Depends on cfid_pkg and contiguous_frame_interval_deque; predicts every result.
`timescale 1ns / 100ps

module tb_contiguous_frame_interval_deque;
    import cfid_pkg::*;

    localparam int DEPTH = DEF_NUM_FRAMES;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] picture;
        logic [47:0] fbegin;
        logic [47:0] ffinish;
        logic [47:0] sstart;
        logic [47:0] sstop;
        logic        svalid;
        logic [6:0]  held;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  command = '0;
    logic [47:0] start_time = '0;
    logic [47:0] end_time = '0;
    logic [31:0] picture_handle = '0;
    logic [47:0] query_time = '0;
    logic [6:0]  trim_count = '0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] picture_out;
    logic [47:0] frame_begin;
    logic [47:0] frame_finish;
    logic [47:0] span_start;
    logic [47:0] span_stop;
    logic        span_valid;
    logic [6:0]  frames_held;

    // Predicted state of the deque.
    logic [47:0] pr_start [DEPTH];
    logic [47:0] pr_end [DEPTH];
    logic [31:0] pr_handle [DEPTH];
    int unsigned pr_head;
    int unsigned pr_count;
    logic [47:0] pr_bstart;
    logic [47:0] pr_bstop;
    logic        pr_bok;

    frame_result_t pending_results[$];
    int error_count = 0;
    int result_count = 0;
    int item_count = 0;
    longint cycle_count = 0;
    int send_idle_pct = 0;

    always #5 clk = ~clk;

    contiguous_frame_interval_deque u_top (.*);

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 result_count);
        error_count++;
    endtask

    // Compute the result of one command and update the predicted deque.
    function automatic frame_result_t predict_deque(input logic [2:0] cmd,
            input logic [47:0] ts, input logic [47:0] te, input logic [31:0] ph,
            input logic [47:0] q, input logic [6:0] n);
        frame_result_t r;
        int unsigned s;
        r = '0;
        r.status = ST_OK;
        case (classify(cmd))
            OP_APPEND:
            begin
                if (te <= ts)
                    r.status = ST_BAD_IVL;
                else if (pr_count == 0)
                begin
                    pr_head = 0;
                    pr_start[0] = ts; pr_end[0] = te; pr_handle[0] = ph;
                    pr_count = 1;
                    pr_bstart = ts; pr_bstop = te; pr_bok = 1'b1;
                end
                else if (ts == pr_bstop)
                begin
                    if (pr_count >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        s = (pr_head + pr_count) % DEPTH;
                        pr_start[s] = ts; pr_end[s] = te; pr_handle[s] = ph;
                        pr_count++;
                        pr_bstop = te;
                    end
                end
                else if (te == pr_bstart)
                begin
                    if (pr_count >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        pr_head = (pr_head + DEPTH - 1) % DEPTH;
                        pr_start[pr_head] = ts; pr_end[pr_head] = te;
                        pr_handle[pr_head] = ph;
                        pr_count++;
                        pr_bstart = ts;
                    end
                end
                else
                    r.status = ST_NOT_ADJ;
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (pr_count == 0)
                begin
                    r.status = ST_EMPTY;
                    pr_bstart = '0; pr_bstop = '0; pr_bok = 1'b0;
                end
                else if (classify(cmd) == OP_POP_FRONT)
                begin
                    pr_bstart = pr_end[pr_head];
                    r.picture = pr_handle[pr_head];
                    pr_head = (pr_head + 1) % DEPTH;
                    pr_count--;
                end
                else
                begin
                    s = (pr_head + pr_count - 1) % DEPTH;
                    pr_bstop = pr_start[s];
                    r.picture = pr_handle[s];
                    pr_count--;
                end
            end
            OP_FIND:
            begin
                r.status = ST_EMPTY;
                for (int k = 0; k < pr_count; k++)
                begin
                    s = (pr_head + k) % DEPTH;
                    if (pr_start[s] <= q && q < pr_end[s])
                    begin
                        r.status = ST_OK;
                        r.picture = pr_handle[s];
                        r.fbegin = pr_start[s];
                        r.ffinish = pr_end[s];
                        break;
                    end
                end
            end
            OP_TRIM_FRONT, OP_TRIM_BACK:
            begin
                if (n > pr_count)
                    r.status = ST_COUNT;
                else
                begin
                    if (classify(cmd) == OP_TRIM_FRONT)
                        pr_head = (pr_head + n) % DEPTH;
                    pr_count -= n;
                    if (pr_count == 0)
                    begin
                        pr_bstart = '0; pr_bstop = '0; pr_bok = 1'b0;
                    end
                    else
                    begin
                        pr_bstart = pr_start[pr_head];
                        pr_bstop = pr_end[(pr_head + pr_count - 1) % DEPTH];
                        pr_bok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.sstart = pr_bstart;
        r.sstop = pr_bstop;
        r.svalid = pr_bok;
        r.held = 7'(pr_count);
        return r;
    endfunction

    // Send one command; its expectation is queued when the transfer happens.
    // Start stays high after the transfer until the next command or a drain.
    task automatic send_command(input logic [2:0] cmd, input logic [47:0] ts,
            input logic [47:0] te, input logic [31:0] ph, input logic [47:0] q,
            input logic [6:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        start_time <= ts;
        end_time <= te;
        picture_handle <= ph;
        query_time <= q;
        trim_count <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_deque(cmd, ts, te, ph, q, n));
        item_count++;
    endtask

    // Check each result against the oldest expectation.
    always @(posedge clk)
    begin
        frame_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status) report_mismatch("status", status, e.status);
                if (picture_out !== e.picture)
                    report_mismatch("picture_out", picture_out, e.picture);
                if (frame_begin !== e.fbegin)
                    report_mismatch("frame_begin", frame_begin, e.fbegin);
                if (frame_finish !== e.ffinish)
                    report_mismatch("frame_finish", frame_finish, e.ffinish);
                if (span_start !== e.sstart)
                    report_mismatch("span_start", span_start, e.sstart);
                if (span_stop !== e.sstop)
                    report_mismatch("span_stop", span_stop, e.sstop);
                if (span_valid !== e.svalid)
                    report_mismatch("span_valid", span_valid, e.svalid);
                if (frames_held !== e.held)
                    report_mismatch("frames_held", frames_held, e.held);
            end
            result_count++;
        end
    end

    function automatic logic [47:0] rand_time();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] rand_len();
        case ($urandom_range(3))
            0: return 48'd1;
            1: return 48'($urandom_range(1, 16));
            2: return 48'($urandom_range(1, 1000));
            default: return {16'd0, $urandom()} + 48'd1;
        endcase
    endfunction

    // Stop sending and wait until every expected result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, every operation and each special case but the full buffer.
    task automatic test_directed();
        send_command(CMD_POP_FRONT, 0, 0, 0, 0, 0);
        send_command(CMD_FIND, 0, 0, 0, 0, 0);
        send_command(CMD_TRIM_FRONT, 0, 0, 0, 0, 0);
        send_command(CMD_TRIM_BACK, 0, 0, 0, 0, 7'd1);
        send_command(CMD_APPEND, 48'd100, 48'd100, 32'h1, 0, 0);
        send_command(CMD_APPEND, 48'd100, 48'd200, 32'hFFFF_FFFF, 0, 0);
        send_command(CMD_APPEND, 48'd200, 48'hFFFF_FFFF_FFFF, 32'h2, 0, 0);
        send_command(CMD_APPEND, 48'd0, 48'd100, 32'h3, 0, 0);
        send_command(CMD_APPEND, 48'd5, 48'd7, 32'h4, 0, 0);
        send_command(CMD_FIND, 0, 0, 0, 48'd0, 0);
        send_command(CMD_FIND, 0, 0, 0, 48'hFFFF_FFFF_FFFE, 0);
        send_command(CMD_FIND, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
        send_command(3'd6, 48'hFFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 7'h7F);
        send_command(3'd7, 0, 0, 0, 0, 0);
        send_command(CMD_TRIM_FRONT, 0, 0, 0, 0, 7'd64);
        send_command(CMD_TRIM_BACK, 0, 0, 0, 0, 7'd1);
        send_command(CMD_POP_FRONT, 0, 0, 0, 0, 0);
        send_command(CMD_POP_BACK, 0, 0, 0, 0, 0);
        send_command(CMD_POP_BACK, 0, 0, 0, 0, 0);
        send_command(CMD_APPEND, 48'd10, 48'd20, 32'h5, 0, 0);
        send_command(CMD_TRIM_BACK, 0, 0, 0, 0, 7'd1);
        send_command(CMD_TRIM_FRONT, 0, 0, 0, 0, 7'h7F);
        drain_results();
    endtask

    // Fill to capacity, hit the full error on both ends, then empty by trim.
    task automatic test_full_buffer();
        logic [47:0] t;
        t = 48'h8000_0000_0000;
        send_command(CMD_APPEND, t, t + 1, $urandom(), 0, 0);
        for (int i = 1; i < DEPTH; i++)
        begin
            if (i % 2)
                send_command(CMD_APPEND, pr_bstop, pr_bstop + rand_len(), $urandom(), 0, 0);
            else
                send_command(CMD_APPEND, pr_bstart - 3, pr_bstart, $urandom(), 0, 0);
        end
        send_command(CMD_APPEND, pr_bstop, pr_bstop + 1, 32'h6, 0, 0);
        send_command(CMD_APPEND, pr_bstart - 1, pr_bstart, 32'h7, 0, 0);
        for (int i = 0; i < 20; i++)
            send_command(CMD_FIND, 0, 0, 0,
                         pr_bstart + 48'($urandom_range(0, 2000)), 0);
        send_command(CMD_TRIM_BACK, 0, 0, 0, 0, 7'd65);
        send_command(CMD_TRIM_BACK, 0, 0, 0, 0, 7'd30);
        send_command(CMD_TRIM_FRONT, 0, 0, 0, 0, 7'd34);
        drain_results();
    endtask

    // Random traffic, adjacent appends most often, with random content.
    task automatic test_random(input int items, input int idle_pct);
        int sel;
        logic [47:0] ts, te, q;
        send_idle_pct = idle_pct;
        for (int i = 0; i < items; i++)
        begin
            sel = $urandom_range(99);
            ts = rand_time();
            te = rand_time();
            q = rand_time();
            if (sel < 30 && pr_count > 0)
            begin
                te = pr_bstop + rand_len();
                send_command(CMD_APPEND, pr_bstop, te, $urandom(), 0, 0);
            end
            else if (sel < 45 && pr_count > 0)
            begin
                ts = pr_bstart - rand_len();
                send_command(CMD_APPEND, ts, pr_bstart, $urandom(), 0, 0);
            end
            else if (sel < 50)
                send_command(CMD_APPEND, ts, ($urandom_range(1)) ? ts + rand_len() : te,
                             $urandom(), 0, 0);
            else if (sel < 70)
            begin
                if (pr_bok && $urandom_range(3) != 0)
                    q = pr_bstart + 48'($urandom_range(0, 3000));
                send_command(CMD_FIND, ts, te, $urandom(), q, 7'($urandom()));
            end
            else if (sel < 78)
                send_command(CMD_POP_FRONT, ts, te, $urandom(), q, 7'($urandom()));
            else if (sel < 86)
                send_command(CMD_POP_BACK, ts, te, $urandom(), q, 7'($urandom()));
            else if (sel < 98)
                send_command(($urandom_range(1)) ? CMD_TRIM_FRONT : CMD_TRIM_BACK,
                             ts, te, $urandom(), q,
                             7'($urandom_range(0, pr_count + ($urandom_range(3) == 0 ? 70 : 1))));
            else
                send_command(3'($urandom_range(6, 7)), ts, te, $urandom(), q, 7'($urandom()));
            if (i == items / 2)
                drain_results();
        end
        send_idle_pct = 0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        pr_head = 0;
        pr_count = 0;
        pr_bstart = '0;
        pr_bstop = '0;
        pr_bok = 1'b0;
        test_directed();
        test_full_buffer();
        test_random(460, 0);
        test_random(460, 60);
        test_random(460, 0);
        test_random(460, 36);
        drain_results();
        repeat (30) @(posedge clk);
        $display("covered %0d commands and %0d results: appends at both ends, pops,",
                 item_count, result_count);
        $display("finds, trims, full and empty cases, under varied sender gaps");
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
